>>> design/drt_pkg.sv
package drt_pkg;

    localparam int MaxDirty = 16;
    localparam int IdxW     = $clog2(MaxDirty);
    localparam int CntW     = $clog2(MaxDirty + 1);

    localparam logic [1:0] ACT_CLEAR  = 2'd0;
    localparam logic [1:0] ACT_ADD    = 2'd1;
    localparam logic [1:0] ACT_QUERY  = 2'd2;
    localparam logic [1:0] ACT_REPORT = 2'd3;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_IGNORED = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    localparam logic [35:0] AreaMax = 36'hF_FFFF_FFFF;

    typedef struct packed {
        logic signed [15:0] h;
        logic signed [15:0] w;
        logic signed [15:0] y;
        logic signed [15:0] x;
    } t_box;

    typedef struct packed {
        logic [1:0]  action;
        t_box        rect;
        logic        use_clip;
        t_box        clip;
    } t_in;

    typedef struct packed {
        logic [1:0]  status;
        logic        hit;
        logic [4:0]  entry_count;
        logic [35:0] area_total;
    } t_out;

    function automatic logic box_empty(t_box b);
        return (b.w <= 0) || (b.h <= 0);
    endfunction

    // Inner is non-empty and lies within outer; edges formed at 17 bits.
    function automatic logic box_holds(t_box o, t_box i);
        logic signed [16:0] ox2, oy2, ix2, iy2;
        ox2 = 17'(o.x) + 17'(o.w);
        oy2 = 17'(o.y) + 17'(o.h);
        ix2 = 17'(i.x) + 17'(i.w);
        iy2 = 17'(i.y) + 17'(i.h);
        return !box_empty(i) && (i.x >= o.x) && (i.y >= o.y) &&
               (ix2 <= ox2) && (iy2 <= oy2);
    endfunction

    // True when the intersection of two boxes is non-empty.
    function automatic logic box_overlap(t_box a, t_box b);
        logic signed [16:0] ax2, ay2, bx2, by2, x1, y1, x2, y2;
        ax2 = 17'(a.x) + 17'(a.w);
        ay2 = 17'(a.y) + 17'(a.h);
        bx2 = 17'(b.x) + 17'(b.w);
        by2 = 17'(b.y) + 17'(b.h);
        x1  = (a.x > b.x) ? 17'(a.x) : 17'(b.x);
        y1  = (a.y > b.y) ? 17'(a.y) : 17'(b.y);
        x2  = (ax2 < bx2) ? ax2 : bx2;
        y2  = (ay2 < by2) ? ay2 : by2;
        return (x2 > x1) && (y2 > y1);
    endfunction

endpackage

>>> design/drt_if.sv
interface drt_in_if;
    import drt_pkg::*;
    logic valid;
    logic ready;
    t_in  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface drt_out_if;
    import drt_pkg::*;
    logic valid;
    logic ready;
    t_out data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> design/drt_mem.sv
module drt_mem (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [drt_pkg::IdxW-1:0]   i_waddr,
    input  drt_pkg::t_box              i_wdata,
    input  logic [drt_pkg::IdxW-1:0]   i_raddr,
    output drt_pkg::t_box              o_rdata
);
    import drt_pkg::*;

    t_box r_mem [MaxDirty];

    // One write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

>>> design/dirty_rect_table.sv
// Clear, an empty add and an empty query skip the table walk; query and report
// walk the table once, and one table walk reads one stored entry per cycle; a
// non-empty add walks once for the containment check and, if no entry covers
// it, walks again for compaction.
// One item is in work at a time; the next is taken only after the result has been taken.
// Synchronous active-low reset empties the table by zeroing the entry count;
// the table memory itself is not cleared.
module dirty_rect_table (
    input  logic        i_clk,
    input  logic        i_rst_n,
    drt_in_if.sink      s_in,
    drt_out_if.source   m_out
);
    import drt_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_SCAN, S_COMPACT, S_DONE} t_state;

    t_state          r_state;
    t_in             r_item;
    t_box            r_rect;
    logic [CntW-1:0] r_count, r_idx, r_wr, r_rd;
    logic            r_rvalid;
    logic            r_flag;
    logic [36:0]     r_area;
    logic            r_we;
    logic [IdxW-1:0] r_waddr;
    t_box            r_wdata;
    t_box            w_rdata;
    logic            r_waddr_full;

    drt_mem u_mem (
        .i_clk  (i_clk),
        .i_we   (r_we),
        .i_waddr(r_waddr),
        .i_wdata(r_wdata),
        .i_raddr(r_idx[IdxW-1:0]),
        .o_rdata(w_rdata)
    );

    assign s_in.ready = (r_state == S_IDLE) && !m_out.valid;

    // Query rectangle after optional clip (non-empty means usable).
    t_box w_qbox;
    logic w_qempty;
    always_comb begin
        logic signed [16:0] x2, y2, cx2, cy2, rx2, ry2, x1, y1;
        rx2 = 17'(s_in.data.rect.x) + 17'(s_in.data.rect.w);
        ry2 = 17'(s_in.data.rect.y) + 17'(s_in.data.rect.h);
        cx2 = 17'(s_in.data.clip.x) + 17'(s_in.data.clip.w);
        cy2 = 17'(s_in.data.clip.y) + 17'(s_in.data.clip.h);
        x1  = (s_in.data.rect.x > s_in.data.clip.x) ? 17'(s_in.data.rect.x)
                                                    : 17'(s_in.data.clip.x);
        y1  = (s_in.data.rect.y > s_in.data.clip.y) ? 17'(s_in.data.rect.y)
                                                    : 17'(s_in.data.clip.y);
        x2  = (rx2 < cx2) ? rx2 : cx2;
        y2  = (ry2 < cy2) ? ry2 : cy2;
        w_qbox = s_in.data.rect;
        if (s_in.data.use_clip) begin
            w_qbox.x = x1[15:0];
            w_qbox.y = y1[15:0];
            if ((x2 <= x1) || (y2 <= y1)) begin
                w_qbox.w = '0;
                w_qbox.h = '0;
            end else begin
                w_qbox.w = 16'(x2 - x1);
                w_qbox.h = 16'(y2 - y1);
            end
        end
        w_qempty = box_empty(w_qbox);
    end

    logic [31:0] w_prod;
    assign w_prod = 32'(w_rdata.w) * 32'(w_rdata.h);

    // Sequencer: issue reads at r_idx, consume the registered read data in the following cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            m_out.valid <= 1'b0;
            r_rvalid    <= 1'b0;
            r_we        <= 1'b0;
        end else begin
            if (m_out.valid && m_out.ready) begin
                m_out.valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    r_we <= 1'b0;
                    if (s_in.valid && s_in.ready) begin
                        r_item   <= s_in.data;
                        r_rect   <= (s_in.data.action == ACT_QUERY) ? w_qbox
                                                                    : s_in.data.rect;
                        r_idx    <= '0;
                        r_rvalid <= 1'b0;
                        r_area   <= '0;
                        case (s_in.data.action)
                            ACT_CLEAR: begin
                                r_count <= '0;
                                r_flag  <= 1'b0;
                                r_state <= S_DONE;
                            end
                            ACT_ADD: begin
                                r_flag  <= box_empty(s_in.data.rect);
                                r_state <= box_empty(s_in.data.rect) ? S_DONE : S_SCAN;
                            end
                            ACT_QUERY: begin
                                r_flag  <= 1'b0;
                                r_state <= w_qempty ? S_DONE : S_SCAN;
                            end
                            default: begin
                                r_flag  <= 1'b0;
                                r_state <= S_SCAN;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    // r_flag: add covered / query hit.
                    r_we     <= 1'b0;
                    r_rvalid <= (r_idx < r_count);
                    if (r_idx < r_count) begin
                        r_idx <= r_idx + 1'b1;
                    end
                    if (r_rvalid) begin
                        case (r_item.action)
                            ACT_ADD: if (box_holds(w_rdata, r_rect)) r_flag <= 1'b1;
                            ACT_QUERY: if (box_overlap(r_rect, w_rdata)) r_flag <= 1'b1;
                            default: if (!box_empty(w_rdata)) begin
                                r_area <= (r_area + 37'(w_prod) > 37'(AreaMax))
                                          ? 37'(AreaMax) : r_area + 37'(w_prod);
                            end
                        endcase
                    end
                    if (!r_rvalid && r_idx >= r_count) begin
                        if (r_item.action == ACT_ADD && !r_flag) begin
                            r_idx   <= '0;
                            r_wr    <= '0;
                            r_state <= S_COMPACT;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_COMPACT: begin
                    // Writes trail reads, so a write never hits an unread entry.
                    r_rvalid <= (r_idx < r_count);
                    if (r_idx < r_count) begin
                        r_idx <= r_idx + 1'b1;
                    end
                    if (!r_rvalid && r_idx >= r_count) begin
                        if (r_wr >= CntW'(MaxDirty)) begin
                            r_we    <= 1'b0;
                            r_count <= r_wr;
                            r_flag  <= 1'b1;
                        end else begin
                            r_we    <= 1'b1;
                            r_waddr <= r_wr[IdxW-1:0];
                            r_wdata <= r_rect;
                            r_count <= r_wr + 1'b1;
                            r_flag  <= 1'b0;
                        end
                        r_state <= S_DONE;
                    end else if (r_rvalid && !box_holds(r_rect, w_rdata)) begin
                        r_we    <= 1'b1;
                        r_waddr <= r_wr[IdxW-1:0];
                        r_wdata <= w_rdata;
                        r_wr    <= r_wr + 1'b1;
                    end else begin
                        r_we <= 1'b0;
                    end
                end
                S_DONE: begin
                    r_we <= 1'b0;
                    if (!m_out.valid) begin
                        m_out.valid <= 1'b1;
                        m_out.data.status <= (r_item.action == ACT_ADD && r_flag)
                                             ? (r_waddr_full ? ST_FULL : ST_IGNORED)
                                             : ST_DONE;
                        m_out.data.hit    <= (r_item.action == ACT_QUERY) && r_flag;
                        m_out.data.entry_count <= 5'(r_count);
                        m_out.data.area_total  <= (r_item.action == ACT_REPORT)
                                                  ? r_area[35:0] : '0;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_we    <= 1'b0;
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Marks that the last add ended at the table-full drop.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_waddr_full <= 1'b0;
        end else if (r_state == S_IDLE) begin
            r_waddr_full <= 1'b0;
        end else if (r_state == S_COMPACT && !r_rvalid && r_idx >= r_count) begin
            r_waddr_full <= (r_wr >= CntW'(MaxDirty));
        end
    end
endmodule

>>> sim/drt_checker.sv
module drt_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    drt_in_if.sink     s_in,
    drt_out_if.sink    m_out,
    output int         o_fail_count,
    output int         o_pending
);
    import drt_pkg::*;

    // Shadow copy of the rectangle table.
    t_box  table_q[$];
    t_out  expected_q[$];
    int    fail_count;

    assign o_fail_count = fail_count;
    assign o_pending    = expected_q.size();

    function automatic logic rect_empty(t_box b);
        return (b.w <= 0) || (b.h <= 0);
    endfunction

    function automatic int right_edge(t_box b);
        return int'(b.x) + int'(b.w);
    endfunction

    function automatic int bottom_edge(t_box b);
        return int'(b.y) + int'(b.h);
    endfunction

    // Outer holds inner when inner is non-empty and inside it.
    function automatic logic rect_contains(t_box o, t_box i);
        return !rect_empty(i) && i.x >= o.x && i.y >= o.y &&
               right_edge(i) <= right_edge(o) && bottom_edge(i) <= bottom_edge(o);
    endfunction

    // Intersection, with an empty result folded to zero size.
    function automatic t_box rect_intersect(t_box a, t_box b);
        t_box r;
        int   x1, y1, x2, y2;
        x1 = (a.x > b.x) ? int'(a.x) : int'(b.x);
        y1 = (a.y > b.y) ? int'(a.y) : int'(b.y);
        x2 = (right_edge(a) < right_edge(b)) ? right_edge(a) : right_edge(b);
        y2 = (bottom_edge(a) < bottom_edge(b)) ? bottom_edge(a) : bottom_edge(b);
        r.x = x1[15:0];
        r.y = y1[15:0];
        if (x2 <= x1 || y2 <= y1) begin
            r.w = '0;
            r.h = '0;
        end else begin
            r.w = 16'(x2 - x1);
            r.h = 16'(y2 - y1);
        end
        return r;
    endfunction

    // Applies one item to the shadow table and returns its result.
    function automatic t_out apply_action(t_in it);
        t_out    res;
        t_box    r;
        logic    covered;
        logic [36:0] area;
        t_box    kept[$];
        res = '0;
        r = it.rect;
        case (it.action)
            ACT_CLEAR: begin
                table_q.delete();
            end
            ACT_ADD: begin
                covered = rect_empty(r);
                foreach (table_q[k])
                    if (rect_contains(table_q[k], r)) covered = 1'b1;
                if (covered) begin
                    res.status = ST_IGNORED;
                end else begin
                    foreach (table_q[k])
                        if (!rect_contains(r, table_q[k])) kept = {kept, table_q[k]};
                    table_q = kept;
                    if (table_q.size() >= MaxDirty) res.status = ST_FULL;
                    else table_q = {table_q, r};
                end
            end
            ACT_QUERY: begin
                if (it.use_clip) r = rect_intersect(r, it.clip);
                if (!rect_empty(r))
                    foreach (table_q[k])
                        if (!rect_empty(rect_intersect(r, table_q[k]))) res.hit = 1'b1;
            end
            default: begin
                area = '0;
                foreach (table_q[k]) begin
                    area += 37'(36'(unsigned'(table_q[k].w)) * 36'(unsigned'(table_q[k].h)));
                    if (area > 37'(AreaMax)) area = 37'(AreaMax);
                end
                res.area_total = area[35:0];
            end
        endcase
        res.entry_count = 5'(table_q.size());
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
        fail_count++;
    endtask

    // Watch both channels at each rising edge.
    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            table_q.delete();
            expected_q.delete();
        end else begin
            if (m_out.valid && m_out.ready) begin
                if (expected_q.size() == 0) begin
                    report_mismatch("unexpected item", 64'(m_out.data), 64'd0);
                end else begin
                    want = expected_q.pop_front();
                    if (m_out.data.status !== want.status)
                        report_mismatch("status", 64'(m_out.data.status), 64'(want.status));
                    if (m_out.data.hit !== want.hit)
                        report_mismatch("hit", 64'(m_out.data.hit), 64'(want.hit));
                    if (m_out.data.entry_count !== want.entry_count)
                        report_mismatch("entry_count", 64'(m_out.data.entry_count),
                                        64'(want.entry_count));
                    if (m_out.data.area_total !== want.area_total)
                        report_mismatch("area_total", 64'(m_out.data.area_total),
                                        64'(want.area_total));
                end
            end
            if (s_in.valid && s_in.ready)
                expected_q = {expected_q, apply_action(s_in.data)};
        end
    end

    initial fail_count = 0;
endmodule

>>> sim/tb.sv
module tb;
    import drt_pkg::*;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    bit   steady;

    drt_in_if  in_ch();
    drt_out_if out_ch();

    dirty_rect_table dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s_in    (in_ch.sink),
        .m_out   (out_ch.source)
    );

    drt_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_in         (in_ch.sink),
        .m_out        (out_ch.sink),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Random edge values with a bias toward small coordinates and boundaries.
    function automatic logic [15:0] pick_coord();
        case ($urandom_range(0, 9))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'(int'($urandom_range(0, 65535)));
            default: return 16'(int'($urandom_range(0, 40)) - 8);
        endcase
    endfunction

    function automatic logic [15:0] pick_size();
        case ($urandom_range(0, 11))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'd0;
            3: return 16'(int'($urandom_range(0, 65535)));
            4: return 16'hFFFF;
            default: return 16'($urandom_range(1, 24));
        endcase
    endfunction

    function automatic t_box pick_box();
        t_box b;
        b.x = pick_coord();
        b.y = pick_coord();
        b.w = pick_size();
        b.h = pick_size();
        return b;
    endfunction

    function automatic t_box mk_box(int x, int y, int w, int h);
        t_box b;
        b.x = 16'(x);
        b.y = 16'(y);
        b.w = 16'(w);
        b.h = 16'(h);
        return b;
    endfunction

    // Send one item and wait for it to be taken; valid stays high for the next.
    task automatic send_item(logic [1:0] act, t_box r, logic clip_on, t_box c);
        while (!steady && $urandom_range(0, 99) < 8) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.data.action   <= act;
        in_ch.data.rect     <= r;
        in_ch.data.use_clip <= clip_on;
        in_ch.data.clip     <= c;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    // Receiver stalls at random, except while steady is set.
    always @(posedge i_clk) begin
        if (!i_rst_n) out_ch.ready <= 1'b0;
        else out_ch.ready <= steady || ($urandom_range(0, 99) >= 8);
    end

    initial begin
        #3000000;
        $display("tb failed");
        $finish;
    end

    initial begin
        t_box z;
        int   sel;
        int   wait_cycles;
        z = '0;
        steady = 1'b0;
        i_rst_n = 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.data  <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty adds, covering, removal, full table, extremes.
        send_item(ACT_REPORT, z, 1'b0, z);
        send_item(ACT_ADD, mk_box(0, 0, 0, 5), 1'b0, z);
        send_item(ACT_ADD, mk_box(0, 0, 5, -1), 1'b0, z);
        send_item(ACT_ADD, mk_box(0, 0, 10, 10), 1'b0, z);
        send_item(ACT_ADD, mk_box(2, 2, 3, 3), 1'b0, z);
        send_item(ACT_ADD, mk_box(-5, -5, 40, 40), 1'b0, z);
        send_item(ACT_QUERY, mk_box(30, 30, 10, 10), 1'b0, z);
        send_item(ACT_QUERY, mk_box(30, 30, 10, 10), 1'b1, mk_box(50, 50, 4, 4));
        send_item(ACT_QUERY, mk_box(0, 0, 0, 0), 1'b0, z);
        send_item(ACT_QUERY, mk_box(1, 1, 2, 2), 1'b1, mk_box(-32768, -32768, -1, 5));
        for (int k = 0; k < 17; k++)
            send_item(ACT_ADD, mk_box(100 + 3 * k, 0, 2, 2), 1'b0, z);
        send_item(ACT_ADD, mk_box(-32768, -32768, 32767, 32767), 1'b0, z);
        send_item(ACT_ADD, mk_box(32767, 32767, 32767, 32767), 1'b1, mk_box(-1, -1, -1, -1));
        send_item(ACT_REPORT, z, 1'b0, z);
        send_item(ACT_CLEAR, z, 1'b0, z);
        send_item(ACT_REPORT, z, 1'b0, z);

        // Random: mostly adds so the table fills, with clears now and then.
        for (int n = 0; n < 450; n++) begin
            steady = (n >= 200 && n < 260);
            sel = $urandom_range(0, 99);
            if (sel < 3)
                send_item(ACT_CLEAR, pick_box(), 1'(($urandom)), pick_box());
            else if (sel < 55)
                send_item(ACT_ADD, pick_box(), 1'(($urandom)), pick_box());
            else if (sel < 85)
                send_item(ACT_QUERY, pick_box(), 1'(($urandom)), pick_box());
            else
                send_item(ACT_REPORT, pick_box(), 1'(($urandom)), pick_box());
        end
        in_ch.valid <= 1'b0;

        wait_cycles = 0;
        while (pending != 0 && wait_cycles < 20000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (50) @(posedge i_clk);
        if (pending == 0 && fail_count == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end
endmodule

>>> files.f
design/drt_pkg.sv
design/drt_if.sv
design/drt_mem.sv
design/dirty_rect_table.sv
sim/drt_checker.sv
sim/tb.sv
